FILE: sv/ctd_pkg.sv
package ctd_pkg;

    // Fixed-point constants (unsigned Q2.30 series arithmetic)
    localparam logic [30:0] Q30_ONE         = 31'h4000_0000;
    localparam logic [24:0] RAD_PER_DEG_Q30 = 25'd18740330;
    localparam logic [14:0] ANGLE_LIMIT     = 15'd23040;
    localparam logic [23:0] DIST_MAX        = 24'hFF_FFFF;

    // Configuration register indexes
    localparam logic [1:0] CFG_X_RESOLUTION      = 2'd0;
    localparam logic [1:0] CFG_DEGREES_PER_PIXEL = 2'd1;
    localparam logic [1:0] CFG_BASELINE_WIDTH    = 2'd2;

    // Horner divisors of the two series and their 2^32 reciprocals
    typedef logic [6:0]  dvsr_t;
    typedef logic [31:0] recip_t;

    localparam dvsr_t COS_D0 = 7'd56;
    localparam dvsr_t COS_D1 = 7'd30;
    localparam dvsr_t COS_D2 = 7'd12;
    localparam dvsr_t COS_D3 = 7'd2;
    localparam dvsr_t SIN_D0 = 7'd72;
    localparam dvsr_t SIN_D1 = 7'd42;
    localparam dvsr_t SIN_D2 = 7'd20;
    localparam dvsr_t SIN_D3 = 7'd6;

    localparam recip_t COS_R0 = 32'((64'd1 << 32) / 64'd56);
    localparam recip_t COS_R1 = 32'((64'd1 << 32) / 64'd30);
    localparam recip_t COS_R2 = 32'((64'd1 << 32) / 64'd12);
    localparam recip_t COS_R3 = 32'((64'd1 << 32) / 64'd2);
    localparam recip_t SIN_R0 = 32'((64'd1 << 32) / 64'd72);
    localparam recip_t SIN_R1 = 32'((64'd1 << 32) / 64'd42);
    localparam recip_t SIN_R2 = 32'((64'd1 << 32) / 64'd20);
    localparam recip_t SIN_R3 = 32'((64'd1 << 32) / 64'd6);

endpackage

FILE: sv/ctd_hstep.sv
// One Horner step: h_out = 1 - floor(((p2 * h_in) >> 30) / dvsr), clamped at 0.
// Three register stages; the division by the constant is a multiply by its
// reciprocal followed by a single correction.
module ctd_hstep (
    input  logic                  aclk,
    input  logic [31:0]           p2_in,
    input  logic [30:0]           h_in,
    input  ctd_pkg::dvsr_t        dvsr,
    input  ctd_pkg::recip_t       recip,
    output logic [31:0]           p2_out,
    output logic [30:0]           h_out
);
    import ctd_pkg::*;

    logic [61:0] prod_reg;
    logic [31:0] p2a_reg;
    logic [31:0] t_reg;
    logic [63:0] tm_reg;
    logic [31:0] p2b_reg;
    logic [30:0] h_reg;
    logic [31:0] p2c_reg;

    logic [31:0] t_next;
    logic [31:0] q0;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [30:0] h_next;

    // Product scaled back to Q2.30
    assign t_next = prod_reg[61:30];

    // Correct the reciprocal estimate, then take one minus
    always_comb begin
        q0   = tm_reg[63:32];
        rem  = t_reg - 32'(q0 * 32'(dvsr));
        quo  = (rem >= 32'(dvsr)) ? q0 + 32'd1 : q0;
        h_next = (quo >= 32'(Q30_ONE)) ? 31'd0 : 31'(32'(Q30_ONE) - quo);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 62'(p2_in) * 62'(h_in);
        p2a_reg  <= p2_in;
        t_reg    <= t_next;
        tm_reg   <= 64'(t_next) * 64'(recip);
        p2b_reg  <= p2a_reg;
        h_reg    <= h_next;
        p2c_reg  <= p2b_reg;
    end

    assign p2_out = p2c_reg;
    assign h_out  = h_reg;

endmodule

FILE: sv/centroid_to_target_distance.sv
// Centroid-to-target distance.
// Input stream: one transfer per target centroid column (s_tdata[11:0]).
// Output stream: one transfer per input, in order: signed Q8.8 offset angle,
// unsigned Q16.8 distance = baseline_width * tan(90 - |angle|), and two flags.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_addr
// (0 image width, 1 degrees per pixel Q0.16, 2 baseline width Q8.8);
// write only while no transfer is in flight.
// Throughput: one item per cycle while s_tready is high; the pipeline
// never stops, and its results land in a 32-entry output queue. Input is
// accepted while fewer than 32 items are in flight (pipeline plus queue),
// so a stalled receiver backs up the input once 32 items are in flight
// and nothing is dropped. The series sits in eight three-stage Horner
// units and the final division is radix-8 over eight stages.
// Reset (aresetn low, synchronous) empties the pipeline and the queue and
// restores the registers to 640, 6554 and 256.
module centroid_to_target_distance #(
    parameter int PIXEL_COORD_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [11:0] centroid_x, [15:12] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    // m_tdata: [15:0] offset_angle, [39:16] distance
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    // m_tuser: [0] cosine_zero, [1] distance_saturated
    output logic [1:0]  m_tuser,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import ctd_pkg::*;

    localparam logic [11:0] CX_MASK = 12'((32'd1 << PIXEL_COORD_BITS) - 32'd1);
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = 5;
    localparam int LAST       = 29;
    localparam int DIV_STAGES = 8;

    typedef struct packed {
        logic [47:0] rem;
        logic [2:0]  qbits;
    } div_res_t;

    // Three restoring-division steps starting at bit position top
    function automatic div_res_t div3(input logic [47:0] rem_in,
                                      input logic [31:0] dv,
                                      input logic [4:0]  top);
        div_res_t    r;
        logic [55:0] sh;
        r.rem   = rem_in;
        r.qbits = 3'd0;
        for (int i = 0; i < 3; i++) begin
            sh = 56'(dv) << (top - 5'(i));
            if (56'(r.rem) >= sh) begin
                r.rem = 48'(56'(r.rem) - sh);
                r.qbits[2 - i] = 1'b1;
            end
        end
        return r;
    endfunction

    // Configuration registers
    logic [11:0] x_res_reg;
    logic [15:0] dpp_reg;
    logic [15:0] bw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_res_reg <= 12'd640;
            dpp_reg   <= 16'd6554;
            bw_reg    <= 16'd256;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_X_RESOLUTION:      x_res_reg <= cfg_wdata[11:0];
                CFG_DEGREES_PER_PIXEL: dpp_reg   <= cfg_wdata;
                CFG_BASELINE_WIDTH:    bw_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake and occupancy
    logic        s_acc;
    logic        m_acc;
    logic [5:0]  inflight_reg;
    logic [5:0]  inflight_next;

    assign s_tready = (inflight_reg != 6'(FIFO_DEPTH));
    assign s_acc    = s_tvalid & s_tready;
    assign m_acc    = m_tvalid & m_tready;

    always_comb begin
        inflight_next = inflight_reg + 6'(s_acc) - 6'(m_acc);
    end

    // Valid bits travel with the data
    logic [LAST:1] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            inflight_reg <= 6'd0;
        end else begin
            vld_reg      <= {vld_reg[LAST-1:1], s_acc};
            inflight_reg <= inflight_next;
        end
    end

    // Stage 1: distance from the centre column
    logic [11:0] cx;
    logic [11:0] half;
    logic        neg;
    logic [11:0] d_next;

    always_comb begin
        cx     = s_tdata[11:0] & CX_MASK;
        half   = {1'b0, x_res_reg[11:1]};
        neg    = cx < half;
        d_next = neg ? half - cx : cx - half;
    end

    logic [11:0] d1_reg;
    logic        neg1_reg;
    logic [27:0] mr2_reg;
    logic        neg2_reg;
    logic [14:0] mag3_reg;
    logic [39:0] pp4_reg;
    logic [30:0] p5_reg;
    logic [61:0] sq6_reg;

    logic [20:0] mag_full;
    logic [14:0] mag_next;

    // Round and saturate the angle magnitude
    always_comb begin
        mag_full = 21'((29'(mr2_reg) + 29'd128) >> 8);
        mag_next = (mag_full > 21'(ANGLE_LIMIT)) ? ANGLE_LIMIT : mag_full[14:0];
    end

    // Stages 1 to 6: angle, radians, square
    always_ff @(posedge aclk) begin
        d1_reg   <= d_next;
        neg1_reg <= neg;
        mr2_reg  <= 28'(d1_reg) * 28'(dpp_reg);
        neg2_reg <= neg1_reg;
        mag3_reg <= mag_next;
        pp4_reg  <= 40'(mag3_reg) * 40'(RAD_PER_DEG_Q30);
        p5_reg   <= 31'((pp4_reg + 40'd128) >> 8);
        sq6_reg  <= 62'(p5_reg) * 62'(p5_reg);
    end

    // Stages 7 to 18: cosine and sine Horner chains
    logic [31:0] cp2 [0:4];
    logic [30:0] ch  [0:4];
    logic [31:0] sp2 [0:4];
    logic [30:0] sh_ [0:4];

    assign cp2[0] = sq6_reg[61:30];
    assign ch[0]  = Q30_ONE;
    assign sp2[0] = sq6_reg[61:30];
    assign sh_[0] = Q30_ONE;

    ctd_hstep u_cos0 (.aclk(aclk), .p2_in(cp2[0]), .h_in(ch[0]), .dvsr(COS_D0),
                      .recip(COS_R0), .p2_out(cp2[1]), .h_out(ch[1]));
    ctd_hstep u_cos1 (.aclk(aclk), .p2_in(cp2[1]), .h_in(ch[1]), .dvsr(COS_D1),
                      .recip(COS_R1), .p2_out(cp2[2]), .h_out(ch[2]));
    ctd_hstep u_cos2 (.aclk(aclk), .p2_in(cp2[2]), .h_in(ch[2]), .dvsr(COS_D2),
                      .recip(COS_R2), .p2_out(cp2[3]), .h_out(ch[3]));
    ctd_hstep u_cos3 (.aclk(aclk), .p2_in(cp2[3]), .h_in(ch[3]), .dvsr(COS_D3),
                      .recip(COS_R3), .p2_out(cp2[4]), .h_out(ch[4]));
    ctd_hstep u_sin0 (.aclk(aclk), .p2_in(sp2[0]), .h_in(sh_[0]), .dvsr(SIN_D0),
                      .recip(SIN_R0), .p2_out(sp2[1]), .h_out(sh_[1]));
    ctd_hstep u_sin1 (.aclk(aclk), .p2_in(sp2[1]), .h_in(sh_[1]), .dvsr(SIN_D1),
                      .recip(SIN_R1), .p2_out(sp2[2]), .h_out(sh_[2]));
    ctd_hstep u_sin2 (.aclk(aclk), .p2_in(sp2[2]), .h_in(sh_[2]), .dvsr(SIN_D2),
                      .recip(SIN_R2), .p2_out(sp2[3]), .h_out(sh_[3]));
    ctd_hstep u_sin3 (.aclk(aclk), .p2_in(sp2[3]), .h_in(sh_[3]), .dvsr(SIN_D3),
                      .recip(SIN_R3), .p2_out(sp2[4]), .h_out(sh_[4]));

    // Hold the angle in radians until the final sine multiply
    logic [30:0] p_dly_reg [6:18];
    // Hold sign and magnitude until the output
    logic [15:0] side_reg  [3:LAST];

    always_ff @(posedge aclk) begin
        p_dly_reg[6] <= p5_reg;
        for (int k = 7; k <= 18; k++) begin
            p_dly_reg[k] <= p_dly_reg[k-1];
        end
        side_reg[3] <= {neg2_reg, mag_next};
        for (int k = 4; k <= LAST; k++) begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    // Stages 19 to 21: sine, rounded numerator, overflow test
    logic [61:0] sprod19_reg;
    logic [46:0] nprod19_reg;
    logic [31:0] s20_reg;
    logic [47:0] n20_reg;
    logic [47:0] rem21_reg;
    logic [31:0] s21_reg;
    logic        ovf21_reg;
    logic        cz21_reg;

    always_ff @(posedge aclk) begin
        sprod19_reg <= 62'(p_dly_reg[18]) * 62'(sh_[4]);
        nprod19_reg <= 47'(bw_reg) * 47'(ch[4]);
        s20_reg     <= sprod19_reg[61:30];
        n20_reg     <= 48'(nprod19_reg) + 48'(sprod19_reg[61:31]);
        rem21_reg   <= n20_reg;
        s21_reg     <= s20_reg;
        ovf21_reg   <= (56'(n20_reg) >= {s20_reg, 24'd0});
        cz21_reg    <= (s20_reg == 32'd0);
    end

    // Stages 22 to 29: radix-8 restoring division
    logic [47:0] dv_rem_reg  [0:DIV_STAGES-1];
    logic [23:0] dv_quo_reg  [0:DIV_STAGES-1];
    logic [31:0] dv_s_reg    [0:DIV_STAGES-1];
    logic [1:0]  dv_flag_reg [0:DIV_STAGES-1];
    div_res_t    dv_res      [0:DIV_STAGES-1];

    always_comb begin
        dv_res[0] = div3(rem21_reg, s21_reg, 5'd23);
        for (int j = 1; j < DIV_STAGES; j++) begin
            dv_res[j] = div3(dv_rem_reg[j-1], dv_s_reg[j-1], 5'(23 - 3 * j));
        end
    end

    always_ff @(posedge aclk) begin
        dv_rem_reg[0]  <= dv_res[0].rem;
        dv_quo_reg[0]  <= {dv_res[0].qbits, 21'd0};
        dv_s_reg[0]    <= s21_reg;
        dv_flag_reg[0] <= {cz21_reg, ovf21_reg};
        for (int j = 1; j < DIV_STAGES; j++) begin
            dv_rem_reg[j]  <= dv_res[j].rem;
            dv_quo_reg[j]  <= dv_quo_reg[j-1] |
                              (24'(dv_res[j].qbits) << (21 - 3 * j));
            dv_s_reg[j]    <= dv_s_reg[j-1];
            dv_flag_reg[j] <= dv_flag_reg[j-1];
        end
    end

    // Format the result
    logic [15:0] angle_out;
    logic [23:0] dist_out;
    logic        cz_out;
    logic        sat_out;

    always_comb begin
        angle_out = side_reg[LAST][15] ? 16'(17'h10000 - 17'(side_reg[LAST][14:0]))
                                       : {1'b0, side_reg[LAST][14:0]};
        cz_out    = dv_flag_reg[DIV_STAGES-1][1];
        sat_out   = !cz_out && dv_flag_reg[DIV_STAGES-1][0];
        if (cz_out) begin
            dist_out = 24'd0;
        end else if (sat_out) begin
            dist_out = DIST_MAX;
        end else begin
            dist_out = dv_quo_reg[DIV_STAGES-1];
        end
    end

    // Output queue
    logic [41:0]        fifo_mem [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] wp_reg;
    logic [FIFO_AW-1:0] rp_reg;
    logic [5:0]         fcnt_reg;

    always_ff @(posedge aclk) begin
        if (vld_reg[LAST]) begin
            fifo_mem[wp_reg] <= {sat_out, cz_out, dist_out, angle_out};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fcnt_reg <= 6'd0;
        end else begin
            if (vld_reg[LAST]) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (m_acc) begin
                rp_reg <= rp_reg + 1'b1;
            end
            fcnt_reg <= fcnt_reg + 6'(vld_reg[LAST]) - 6'(m_acc);
        end
    end

    assign m_tvalid = (fcnt_reg != 6'd0);
    assign m_tdata  = fifo_mem[rp_reg][39:0];
    assign m_tuser  = fifo_mem[rp_reg][41:40];

`ifndef NO_ASSERTIONS
    // Queue occupancy never exceeds the items in flight
    a_fcnt_le_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg <= inflight_reg)
        else $error("output queue holds more than in flight");

    // In-flight count stays within the queue depth
    a_inflight_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 6'(FIFO_DEPTH))
        else $error("in-flight count above queue depth");

    // A zero sine gives zero distance and no saturation
    a_cz_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (!m_tuser[1] && m_tdata[39:16] == 24'd0))
        else $error("cosine_zero result carries a distance");

    // Saturation reports the full-scale distance
    a_sat_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[39:16] == DIST_MAX))
        else $error("saturated result not at full scale");
`endif

endmodule
